// ===== src/ppsg_pkg.sv =====
package ppsg_pkg;

  localparam int unsigned ELAPSED_W = 16;

  localparam int unsigned US_100MS = 100000;
  localparam int unsigned US_200MS = 200000;
  localparam int unsigned US_400MS = 400000;
  localparam int unsigned US_500MS = 500000;
  localparam int unsigned US_1S    = 1000000;
  localparam int unsigned US_2S    = 2000000;
  localparam int unsigned US_4S    = 4000000;

  typedef struct packed {
    logic crossed;
    logic low_half;
  } phase_stat_t;

  typedef struct packed {
    logic div2;
    logic div3;
    logic div5;
  } div_stat_t;

endpackage

// ===== src/ppsg_phase.sv =====
module ppsg_phase #(
  parameter int unsigned PERIOD      = 1000000,
  parameter int unsigned DELTA_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [DELTA_WIDTH-1:0] delta,
  output ppsg_pkg::phase_stat_t  stat
);

  localparam int unsigned RW = $clog2(PERIOD);
  localparam int unsigned SW = RW + 1;
  localparam logic [SW-1:0] PERIOD_S = SW'(PERIOD);
  localparam logic [RW-1:0] HALF_R   = RW'(PERIOD / 2);

  logic [RW-1:0] acc_r;
  logic [RW-1:0] acc_nxt;
  logic [SW-1:0] sum;
  logic          wrap;

  always_comb begin
    sum     = SW'(acc_r) + SW'(delta);
    wrap    = (sum >= PERIOD_S);
    acc_nxt = wrap ? RW'(sum - PERIOD_S) : RW'(sum);
  end

  assign stat.crossed  = wrap;
  assign stat.low_half = (acc_nxt < HALF_R);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (step) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

// ===== src/ppsg_secmod.sv =====
module ppsg_secmod (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tick,
  output ppsg_pkg::div_stat_t stat
);

  logic       m2_r;
  logic       m2_nxt;
  logic [1:0] m3_r;
  logic [1:0] m3_nxt;
  logic [2:0] m5_r;
  logic [2:0] m5_nxt;

  always_comb begin
    m2_nxt = ~m2_r;
    m3_nxt = (m3_r == 2'd2) ? 2'd0 : m3_r + 2'd1;
    m5_nxt = (m5_r == 3'd4) ? 3'd0 : m5_r + 3'd1;
  end

  assign stat.div2 = (m2_nxt == 1'b0);
  assign stat.div3 = (m3_nxt == 2'd0);
  assign stat.div5 = (m5_nxt == 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_r <= 1'b0;
      m3_r <= 2'd0;
      m5_r <= 3'd0;
    end else if (tick) begin
      m2_r <= m2_nxt;
      m3_r <= m3_nxt;
      m5_r <= m5_nxt;
    end
  end

endmodule

// ===== src/periodic_pulse_and_square_wave_gen.sv =====
// An accepted word is registered in s1, then its result word in the out_ registers.
// One word per cycle when not stalled; each phase is one add and compare-subtract.
// Reset (rst_n low, synchronous): the running time and all period phases and
// second-count residues return to zero, and both pipeline registers are emptied.
module periodic_pulse_and_square_wave_gen #(
  parameter int unsigned DELTA_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ppsg_pkg::ELAPSED_W-1:0]   in_elapsed_us,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_pulse_1s,
  output logic                             out_pulse_100ms,
  output logic                             out_pulse_200ms,
  output logic                             out_pulse_500ms,
  output logic                             out_pulse_2s,
  output logic                             out_pulse_3s,
  output logic                             out_pulse_5s,
  output logic                             out_square_1s_period,
  output logic                             out_square_2s_period,
  output logic                             out_square_4s_period,
  output logic                             out_square_400ms_period
);

  logic                   s1_valid_r;
  logic [DELTA_WIDTH-1:0] s1_delta_r;
  logic                   out_valid_r;
  logic                   s2_ready;
  logic                   step;

  logic p1s_r, p100_r, p200_r, p500_r, p2s_r, p3s_r, p5s_r;
  logic sq1_r, sq2_r, sq4_r, sq400_r;

  ppsg_pkg::phase_stat_t st_100ms, st_200ms, st_500ms, st_1s;
  ppsg_pkg::phase_stat_t st_2s, st_4s, st_400ms;
  ppsg_pkg::div_stat_t   dv;

  assign s2_ready = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && s2_ready;
  assign in_stall = s1_valid_r && !s2_ready;

  ppsg_phase #(.PERIOD(ppsg_pkg::US_100MS), .DELTA_WIDTH(DELTA_WIDTH)) u_ph_100ms (
    .clk(clk), .rst_n(rst_n), .step(step), .delta(s1_delta_r), .stat(st_100ms));
  ppsg_phase #(.PERIOD(ppsg_pkg::US_200MS), .DELTA_WIDTH(DELTA_WIDTH)) u_ph_200ms (
    .clk(clk), .rst_n(rst_n), .step(step), .delta(s1_delta_r), .stat(st_200ms));
  ppsg_phase #(.PERIOD(ppsg_pkg::US_500MS), .DELTA_WIDTH(DELTA_WIDTH)) u_ph_500ms (
    .clk(clk), .rst_n(rst_n), .step(step), .delta(s1_delta_r), .stat(st_500ms));
  ppsg_phase #(.PERIOD(ppsg_pkg::US_1S), .DELTA_WIDTH(DELTA_WIDTH)) u_ph_1s (
    .clk(clk), .rst_n(rst_n), .step(step), .delta(s1_delta_r), .stat(st_1s));
  ppsg_phase #(.PERIOD(ppsg_pkg::US_2S), .DELTA_WIDTH(DELTA_WIDTH)) u_ph_2s (
    .clk(clk), .rst_n(rst_n), .step(step), .delta(s1_delta_r), .stat(st_2s));
  ppsg_phase #(.PERIOD(ppsg_pkg::US_4S), .DELTA_WIDTH(DELTA_WIDTH)) u_ph_4s (
    .clk(clk), .rst_n(rst_n), .step(step), .delta(s1_delta_r), .stat(st_4s));
  ppsg_phase #(.PERIOD(ppsg_pkg::US_400MS), .DELTA_WIDTH(DELTA_WIDTH)) u_ph_400ms (
    .clk(clk), .rst_n(rst_n), .step(step), .delta(s1_delta_r), .stat(st_400ms));

  ppsg_secmod u_secmod (
    .clk(clk), .rst_n(rst_n), .tick(step && st_1s.crossed), .stat(dv));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_delta_r <= in_elapsed_us[DELTA_WIDTH-1:0];
    end
    if (step) begin
      p1s_r   <= st_1s.crossed;
      p100_r  <= st_100ms.crossed;
      p200_r  <= st_200ms.crossed;
      p500_r  <= st_500ms.crossed;
      p2s_r   <= st_1s.crossed && dv.div2;
      p3s_r   <= st_1s.crossed && dv.div3;
      p5s_r   <= st_1s.crossed && dv.div5;
      sq1_r   <= st_1s.low_half;
      sq2_r   <= st_2s.low_half;
      sq4_r   <= st_4s.low_half;
      sq400_r <= st_400ms.low_half;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_pulse_1s            = p1s_r;
  assign out_pulse_100ms         = p100_r;
  assign out_pulse_200ms         = p200_r;
  assign out_pulse_500ms         = p500_r;
  assign out_pulse_2s            = p2s_r;
  assign out_pulse_3s            = p3s_r;
  assign out_pulse_5s            = p5s_r;
  assign out_square_1s_period    = sq1_r;
  assign out_square_2s_period    = sq2_r;
  assign out_square_4s_period    = sq4_r;
  assign out_square_400ms_period = sq400_r;

  a_sec_implies_sub: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && p1s_r |-> p500_r && p200_r && p100_r)
    else $error("1 s boundary without sub-period boundaries");

  a_200_implies_100: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && p200_r |-> p100_r)
    else $error("200 ms boundary without 100 ms boundary");

  a_multi_needs_sec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (p2s_r || p3s_r || p5s_r) |-> p1s_r)
    else $error("multi-second pulse without 1 s pulse");

  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && in_stall |=> s1_valid_r && $stable(s1_delta_r))
    else $error("staged word lost while output stalled");

endmodule
